// ----- rtl/core/dqs_pkg.sv -----
// dqs_pkg: shared types and constants of the discrete quantile search block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package dqs_pkg;

   // Field widths
   localparam int LEN_W   = 11;   // table_length register
   localparam int ENTRY_W = 10;   // entry_index and quantile_index
   localparam int VALUE_W = 32;   // signed Q15.16 values

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TABLE_LENGTH = 2'd0;
   localparam logic [LEN_W-1:0]      LEN_RESET        = 11'd1024;

   // Action codes on the input beat
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_QUERY,
      OP_SKIP
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [ENTRY_W-1:0]         index;
      logic signed [VALUE_W-1:0]  value;
      logic signed [VALUE_W-1:0]  level;
   } cmd_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] quantile_index;
      logic               beyond_max;
   } rsp_type;

   // Back-end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CHECK,
      BK_PROBE,
      BK_FINAL
   } back_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/dqs_front.sv -----
// dqs_front: accepts input beats, classifies them and holds them in a
// two-entry command queue for the back end. Depends on dqs_pkg.
`default_nettype none

module dqs_front #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic                                  req_action,
   input  wire logic [dqs_pkg::ENTRY_W-1:0]           req_entry_index,
   input  wire logic signed [dqs_pkg::VALUE_W-1:0]    req_entry_value,
   input  wire logic signed [dqs_pkg::VALUE_W-1:0]    req_query_level,
   output logic                                       cmd_valid,
   output dqs_pkg::cmd_type                           cmd,
   input  wire logic                                  cmd_pop
);
   import dqs_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    incoming;
   logic       do_push, do_pop;

   // Classify the beat; writes past the table are dropped in the back end
   always_comb begin
      incoming.index = req_entry_index;
      incoming.value = req_entry_value;
      incoming.level = req_query_level;
      if (req_action == ACT_QUERY) begin
         incoming.op = OP_QUERY;
      end else if (int'(req_entry_index) < TABLE_DEPTH) begin
         incoming.op = OP_WRITE;
      end else begin
         incoming.op = OP_SKIP;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // Queue pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dqs_back.sv -----
// dqs_back: holds the cumulative table and runs writes and bisection
// queries over its single read port. Depends on dqs_pkg.
`default_nettype none

module dqs_back #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [dqs_pkg::LEN_W-1:0]     table_length,
   input  wire logic                          cmd_valid,
   input  wire dqs_pkg::cmd_type              cmd,
   output logic                               cmd_pop,
   input  wire logic                          rsp_full,
   output logic                               rsp_push,
   output dqs_pkg::rsp_type                   rsp_data
);
   import dqs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   back_state_type            state_ff, state_in;
   logic [LEN_W-1:0]          lo_ff, lo_in;
   logic [LEN_W-1:0]          hi_ff, hi_in;
   logic [LEN_W-1:0]          mid_ff, mid_in;
   logic signed [VALUE_W-1:0] level_ff, level_in;

   logic [LEN_W-1:0]          len_used;
   logic [LEN_W-1:0]          last_idx;
   logic [LEN_W:0]            cur_sum;
   logic [LEN_W-1:0]          cur_mid;
   logic                      probe_ge;
   logic [LEN_W-1:0]          new_lo, new_hi;
   logic [LEN_W:0]            new_sum;
   logic [LEN_W-1:0]          new_mid;
   logic [LEN_W-1:0]          rd_sel;
   logic                      mem_we;
   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          wr_addr;

   // Entries in use: zero acts as one, clamp to the table depth
   always_comb begin
      if (table_length == '0) begin
         len_used = LEN_W'(1);
      end else if (int'(table_length) > TABLE_DEPTH) begin
         len_used = LEN_W'(TABLE_DEPTH);
      end else begin
         len_used = table_length;
      end
      last_idx = len_used - LEN_W'(1);
   end

   // Midpoints of the current and of the narrowed interval
   always_comb begin
      cur_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      cur_mid  = cur_sum[LEN_W:1];
      probe_ge = (rd_data_ff >= level_ff);
      new_lo   = probe_ge ? lo_ff  : mid_ff;
      new_hi   = probe_ge ? mid_ff : hi_ff;
      new_sum  = {1'b0, new_lo} + {1'b0, new_hi};
      new_mid  = new_sum[LEN_W:1];
   end

   // Sequencer: next state, probe address and outputs
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      level_in = level_ff;
      rd_sel   = lo_ff;
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_WRITE: begin
                     mem_we  = 1'b1;
                     cmd_pop = 1'b1;
                  end
                  OP_QUERY: begin
                     // start only with a free result slot
                     if (!rsp_full) begin
                        cmd_pop  = 1'b1;
                        level_in = cmd.level;
                        lo_in    = '0;
                        hi_in    = last_idx;
                        rd_sel   = last_idx;
                        state_in = BK_CHECK;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_CHECK: begin
            // rd_data holds the last entry in use
            if (level_ff > rd_data_ff) begin
               rsp_push                = 1'b1;
               rsp_data.quantile_index = '0;
               rsp_data.beyond_max     = 1'b1;
               state_in                = BK_IDLE;
            end else if ((hi_ff - lo_ff) > LEN_W'(1)) begin
               mid_in   = cur_mid;
               rd_sel   = cur_mid;
               state_in = BK_PROBE;
            end else begin
               rd_sel   = lo_ff;
               state_in = BK_FINAL;
            end
         end
         BK_PROBE: begin
            // rd_data holds the entry at mid
            lo_in = new_lo;
            hi_in = new_hi;
            if ((new_hi - new_lo) > LEN_W'(1)) begin
               mid_in = new_mid;
               rd_sel = new_mid;
            end else begin
               rd_sel   = new_lo;
               state_in = BK_FINAL;
            end
         end
         BK_FINAL: begin
            // rd_data holds the entry at lo
            rsp_push                = 1'b1;
            rsp_data.quantile_index = probe_ge ? lo_ff[ENTRY_W-1:0] : hi_ff[ENTRY_W-1:0];
            rsp_data.beyond_max     = 1'b0;
            state_in                = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rd_addr = IDX_W'(rd_sel);
   assign wr_addr = IDX_W'(cmd.index);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      level_ff <= level_in;
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/dqs_rsp_fifo.sv -----
// dqs_rsp_fifo: two-entry result queue between the back end and the
// result port. Depends on dqs_pkg.
`default_nettype none

module dqs_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_push,
   input  wire dqs_pkg::rsp_type              rsp_data,
   output logic                               rsp_full,
   output logic                               empty,
   input  wire logic                          pop,
   output logic [dqs_pkg::ENTRY_W-1:0]        rsp_quantile_index,
   output logic                               rsp_beyond_max
);
   import dqs_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign rsp_full           = (count_ff == 2'd2);
   assign empty              = (count_ff == 2'd0);
   assign do_push            = rsp_push && !rsp_full;
   assign do_pop             = pop && !empty;
   assign rsp_quantile_index = slot_ff[rd_ptr_ff].quantile_index;
   assign rsp_beyond_max     = slot_ff[rd_ptr_ff].beyond_max;

   // Pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= rsp_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/discrete_quantile_search_top.sv -----
// Discrete quantile search: inverse-CDF lookup by bisection over a table of
// nondecreasing signed Q15.16 cumulative values. A write beat (action 0) stores
// one entry; a query beat (action 1) returns the smallest index among the first
// table_length entries whose value reaches the level, or index 0 with beyond_max
// set when the level exceeds the last entry in use. Entries must be written
// before any query reads them. The front queue takes one beat per cycle while
// it has room. The back end owns the table, a memory with one write port and
// one registered read port, and handles one command at a time: a write is
// stored from IDLE; a query steps through CHECK, then PROBE while its interval
// of entries in use spans more than two, then FINAL. A query whose level is
// beyond the table finishes in CHECK. Results then sit in a two-entry queue
// until popped. table_length is at address 0 of the config port.
// Depends on dqs_pkg, dqs_front, dqs_back and dqs_rsp_fifo.
`default_nettype none

module discrete_quantile_search_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input channel
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic                                  req_action,
   input  wire logic [dqs_pkg::ENTRY_W-1:0]           req_entry_index,
   input  wire logic signed [dqs_pkg::VALUE_W-1:0]    req_entry_value,
   input  wire logic signed [dqs_pkg::VALUE_W-1:0]    req_query_level,
   // result channel
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic [dqs_pkg::ENTRY_W-1:0]                rsp_quantile_index,
   output logic                                       rsp_beyond_max,
   // configuration port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [dqs_pkg::CSR_ADDR_W-1:0]        paddr,
   input  wire logic [dqs_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [dqs_pkg::CSR_DATA_W-1:0]             prdata,
   output logic                                       pready
);
   import dqs_pkg::*;

   logic [LEN_W-1:0] table_length_ff, table_length_in;
   logic             csr_wr;
   logic             cmd_valid;
   cmd_type          cmd;
   logic             cmd_pop;
   logic             rsp_push;
   rsp_type          rsp_data;
   logic             rsp_full;

   // Configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr == CSR_TABLE_LENGTH);
   assign table_length_in = csr_wr ? pwdata[LEN_W-1:0] : table_length_ff;
   assign prdata = (paddr == CSR_TABLE_LENGTH) ?
                   {{(CSR_DATA_W-LEN_W){1'b0}}, table_length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= LEN_RESET;
      end else begin
         table_length_ff <= table_length_in;
      end
   end

   dqs_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_query_level (req_query_level),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   dqs_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .table_length (table_length_ff),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp_data     (rsp_data)
   );

   dqs_rsp_fifo u_rsp_fifo (
      .clock              (clock),
      .reset              (reset),
      .rsp_push           (rsp_push),
      .rsp_data           (rsp_data),
      .rsp_full           (rsp_full),
      .empty              (empty),
      .pop                (pop),
      .rsp_quantile_index (rsp_quantile_index),
      .rsp_beyond_max     (rsp_beyond_max)
   );

`ifndef SYNTH
   // a finished query always finds a free result slot
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result queue overflow");

   // the back end only retires commands that are present
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // a beyond-table result always carries index zero
   a_beyond_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.beyond_max) |-> (rsp_data.quantile_index == '0))
      else $error("beyond_max result with nonzero index");

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (empty && !full && !cmd_valid))
      else $error("queues not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- verif/discrete_quantile_search_top_test.sv -----
// Self-checking testbench for discrete_quantile_search_top: loads the cumulative table,
// runs quantile queries under random push/pop idling and checks every result beat.
// Depends on dqs_pkg and discrete_quantile_search_top.
`timescale 1ns / 1ps

module discrete_quantile_search_top_test;
   import dqs_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int PRELOAD      = 320;    // entries loaded before any query
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 128;    // front queue may still hold writes
   localparam int MAX_GAP      = 12;

   typedef logic signed [VALUE_W-1:0] q16_type;

   localparam q16_type Q16_MIN = 32'sh8000_0000;
   localparam q16_type Q16_MAX = 32'sh7fff_ffff;

   // Shadow of the cumulative table, the length register and the answers in flight
   class quantile_scoreboard;
      q16_type          cdf_table[DEPTH];
      logic [LEN_W-1:0] length_reg;
      rsp_type          answers_due[$];
      int               failures;
      int               n_writes;
      int               n_queries;
      int               n_beyond;
      int               n_checked;

      function new();
         length_reg = LEN_RESET;
         foreach (cdf_table[i]) cdf_table[i] = '0;
         failures  = 0;
         n_writes  = 0;
         n_queries = 0;
         n_beyond  = 0;
         n_checked = 0;
      endfunction

      function void set_length(logic [LEN_W-1:0] value);
         length_reg = value;
      endfunction

      // entries actually searched: zero acts as one, oversize clamps to depth
      function int entries_in_use();
         int unsigned k;
         k = length_reg;
         if (k == 0) k = 1;
         if (k > DEPTH) k = DEPTH;
         return k;
      endfunction

      // fixed bisection, same probe order as the block even for unsorted tables
      function rsp_type search_level(q16_type level);
         rsp_type     ans;
         int unsigned k, lo, hi, mid;
         k = entries_in_use();
         ans.quantile_index = '0;
         ans.beyond_max     = 1'b0;
         if (level > cdf_table[k-1]) begin
            ans.beyond_max = 1'b1;
            return ans;
         end
         lo  = 0;
         hi  = k - 1;
         mid = (lo + hi) >> 1;
         while (hi - lo > 1) begin
            if (cdf_table[mid] >= level) hi = mid;
            else lo = mid;
            mid = (lo + hi) >> 1;
         end
         ans.quantile_index = (cdf_table[lo] >= level) ? ENTRY_W'(lo) : ENTRY_W'(hi);
         return ans;
      endfunction

      function void note_beat(logic action, logic [ENTRY_W-1:0] index, q16_type value,
                              q16_type level);
         rsp_type ans;
         if (action == ACT_WRITE) begin
            cdf_table[index] = value;
            n_writes++;
         end else begin
            ans = search_level(level);
            answers_due = {answers_due, ans};
            n_queries++;
            if (ans.beyond_max) n_beyond++;
         end
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (answers_due.size() == 0) begin
            $display("%0t: result with none expected: index %0d beyond_max %0b",
                     $time, got.quantile_index, got.beyond_max);
            failures++;
            return;
         end
         want = answers_due.pop_front();
         n_checked++;
         if (got.quantile_index !== want.quantile_index) begin
            $display("%0t: quantile_index expected %0d actual %0d",
                     $time, want.quantile_index, got.quantile_index);
            failures++;
         end
         if (got.beyond_max !== want.beyond_max) begin
            $display("%0t: beyond_max expected %0b actual %0b",
                     $time, want.beyond_max, got.beyond_max);
            failures++;
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   // Block ports
   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    push            = 1'b0;
   logic                    full;
   logic                    req_action      = ACT_WRITE;
   logic [ENTRY_W-1:0]      req_entry_index = '0;
   q16_type                 req_entry_value = '0;
   q16_type                 req_query_level = '0;
   logic                    empty;
   logic                    pop             = 1'b0;
   logic [ENTRY_W-1:0]      rsp_quantile_index;
   logic                    rsp_beyond_max;
   logic                    psel            = 1'b0;
   logic                    penable         = 1'b0;
   logic                    pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr           = '0;
   logic [CSR_DATA_W-1:0]   pwdata          = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   quantile_scoreboard sb;
   int                 cycle_count  = 0;
   int                 csr_failures = 0;
   int                 n_lengths    = 0;
   int                 send_calm    = 0;
   int                 pop_calm     = 0;

   discrete_quantile_search_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_action         (req_action),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_query_level    (req_query_level),
      .empty              (empty),
      .pop                (pop),
      .rsp_quantile_index (rsp_quantile_index),
      .rsp_beyond_max     (rsp_beyond_max),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("discrete_quantile_search_top test failed");
         $finish;
      end
   end

   // Idle draws: random gaps, with occasional stretches of back-to-back beats
   function automatic int next_send_gap();
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(10, 40);
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic int next_pop_stall();
      if (pop_calm > 0) begin
         pop_calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) pop_calm = $urandom_range(10, 40);
      return $urandom_range(0, MAX_GAP);
   endfunction

   // One input beat; returns at the edge that accepted it
   task automatic send_beat(logic action, logic [ENTRY_W-1:0] index, q16_type value,
                            q16_type level);
      int gap;
      gap = next_send_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_action      <= action;
      req_entry_index <= index;
      req_entry_value <= value;
      req_query_level <= level;
      do @(posedge clock); while (full);
      sb.note_beat(action, index, value, level);
   endtask

   // unused fields of each beat carry random bits
   task automatic send_write(logic [ENTRY_W-1:0] index, q16_type value);
      send_beat(ACT_WRITE, index, value, q16_type'($urandom));
   endtask

   task automatic send_query(q16_type level);
      send_beat(ACT_QUERY, ENTRY_W'($urandom), q16_type'($urandom), level);
   endtask

   // Hold off input until every answer is back and queued writes have retired
   task automatic wait_drained();
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read(logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_length_reg();
      logic [CSR_DATA_W-1:0] rd;
      csr_read(CSR_TABLE_LENGTH, rd);
      if (rd !== CSR_DATA_W'(sb.length_reg)) begin
         $display("%0t: table_length read expected %0d actual %0d",
                  $time, sb.length_reg, rd);
         csr_failures++;
      end
   endtask

   task automatic set_table_length(logic [LEN_W-1:0] len);
      wait_drained();
      csr_write(CSR_TABLE_LENGTH, CSR_DATA_W'(len));
      // let the bus idle between the write and the read-back
      @(posedge clock);
      sb.set_length(len);
      n_lengths++;
      check_length_reg();
   endtask

   // Random mix: mostly queries (near stored values, past the last entry or random),
   // some order-keeping writes, a few arbitrary writes that break the ordering
   task automatic random_items(int count);
      int      k, idx, sel;
      q16_type lo_v, hi_v, value, level;
      longint  width;
      k = sb.entries_in_use();
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 25) begin
            idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, k - 1)
                                               : $urandom_range(0, DEPTH - 1);
            lo_v  = (idx > 0) ? sb.cdf_table[idx-1] : Q16_MIN;
            hi_v  = (idx < DEPTH - 1) ? sb.cdf_table[idx+1] : Q16_MAX;
            value = q16_type'($urandom);
            if ($urandom_range(0, 5) != 0 && lo_v <= hi_v) begin
               width = longint'(hi_v) - longint'(lo_v) + 1;
               value = q16_type'(longint'(lo_v) + (longint'($urandom) % width));
            end
            send_write(ENTRY_W'(idx), value);
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
               level = sb.cdf_table[$urandom_range(0, k - 1)]
                       + q16_type'($urandom_range(0, 2)) - 1;
            else if (sel < 60)
               level = sb.cdf_table[k-1] + q16_type'($urandom_range(1, 1000));
            else
               level = q16_type'($urandom);
            send_query(level);
         end
      end
   endtask

   // Result side: random pop stalls, each beat checked against the shadow
   initial begin : result_side
      int      stall;
      rsp_type got;
      while (reset) @(posedge clock);
      forever begin
         stall = next_pop_stall();
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got.quantile_index = rsp_quantile_index;
         got.beyond_max     = rsp_beyond_max;
         sb.check_answer(got);
      end
   end

   // Stimulus
   initial begin : stimulus
      longint           acc;
      logic [LEN_W-1:0] phase_len[8];
      sb = new();
      phase_len = '{11'd1, 11'd2, 11'd3, 11'd0, 11'd7, 11'd64, 11'd319, 11'd320};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_length_reg();

      // preload the entries in use with a nondecreasing ramp from the range bottom
      acc = longint'(Q16_MIN);
      for (int i = 0; i < PRELOAD; i++) begin
         send_write(ENTRY_W'(i), q16_type'(acc));
         acc += $urandom_range(0, 1 << 22);
      end
      set_table_length(LEN_W'(PRELOAD));

      // directed: range ends, exact hits, runs of equal values, unsorted table
      send_query(Q16_MIN);
      send_query(Q16_MAX);
      send_query(sb.cdf_table[PRELOAD-1]);
      send_query(sb.cdf_table[PRELOAD-1] + 1);
      send_query(sb.cdf_table[160]);
      send_query(sb.cdf_table[160] + 1);
      send_query(sb.cdf_table[160] - 1);
      send_write(ENTRY_W'(PRELOAD - 1), Q16_MAX);
      send_query(Q16_MAX);
      send_write(10'd11, sb.cdf_table[10]);
      send_write(10'd12, sb.cdf_table[10]);
      send_query(sb.cdf_table[10]);
      send_query(sb.cdf_table[12] + 1);
      send_write(10'd160, Q16_MIN);
      send_query(sb.cdf_table[200]);
      send_query(sb.cdf_table[159]);
      send_write(10'd160, sb.cdf_table[159]);
      send_write(10'd0, Q16_MAX);
      send_query(32'sd0);
      send_query(Q16_MIN);
      send_write(10'd0, Q16_MIN);
      send_query(Q16_MIN + 1);

      // several lengths, including zero and the smallest ones
      foreach (phase_len[p]) begin
         set_table_length(phase_len[p]);
         random_items(40);
      end
      set_table_length(LEN_W'($urandom_range(1, PRELOAD)));
      random_items(40);

      wait_drained();
      $display("Covered %0d table writes and %0d queries (%0d beyond the last entry)",
               sb.n_writes, sb.n_queries, sb.n_beyond);
      $display("over %0d length settings; %0d result beats checked, %0d mismatches",
               n_lengths, sb.n_checked, sb.failures + csr_failures);
      if (sb.failures == 0 && csr_failures == 0 && sb.pending() == 0)
         $display("discrete_quantile_search_top test passed");
      else
         $display("discrete_quantile_search_top test failed");
      $finish;
   end

endmodule
